// ===== hdl/tgr_pkg.sv =====
// Shared types, codes and sizes of the touch gesture recognizer.
`default_nettype none
package tgr_pkg;

    localparam int COORD_BITS   = 12;
    localparam int OP_BITS      = 2;
    localparam int TIME_BITS    = 32;
    localparam int MS_BITS      = 16;
    localparam int RADIUS_BITS  = 12;
    localparam int RSQ_BITS     = 2 * RADIUS_BITS;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int GESTURE_BITS = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_DOWN = 2'd0,
        OP_MOVE = 2'd1,
        OP_UP   = 2'd2,
        OP_TICK = 2'd3
    } t_op;

    typedef enum logic [GESTURE_BITS-1:0] {
        G_NONE   = 3'd0,
        G_LONG   = 3'd1,
        G_SINGLE = 3'd2,
        G_DOUBLE = 3'd3,
        G_SWIPE  = 3'd4
    } t_gesture;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LONG_PRESS_MS = 3'd0,
        CFG_TAP_WINDOW_MS = 3'd1,
        CFG_DRAG_RADIUS   = 3'd2,
        CFG_DTAP_RADIUS   = 3'd3,
        CFG_SWIPE_RADIUS  = 3'd4
    } t_cfg_reg;

    localparam logic [MS_BITS-1:0]  LONG_PRESS_RST = 16'd500;
    localparam logic [MS_BITS-1:0]  TAP_WINDOW_RST = 16'd300;
    localparam logic [RSQ_BITS-1:0] DRAG_SQ_RST    = 24'd2500;
    localparam logic [RSQ_BITS-1:0] DTAP_SQ_RST    = 24'd10000;
    localparam logic [RSQ_BITS-1:0] SWIPE_SQ_RST   = 24'd22500;

endpackage
`default_nettype wire

// ===== hdl/tgr_if.sv =====
// Valid/ready channel interfaces for touch events and gesture results.
`default_nettype none
interface tgr_event_if #(
    parameter int COORD_BITS = tgr_pkg::COORD_BITS
);
    logic                            valid;
    logic                            ready;
    logic [tgr_pkg::OP_BITS-1:0]     op;
    logic [COORD_BITS-1:0]           pos_x;
    logic [COORD_BITS-1:0]           pos_y;
    logic [tgr_pkg::TIME_BITS-1:0]   time_ms;

    modport source (output valid, op, pos_x, pos_y, time_ms, input ready);
    modport sink   (input valid, op, pos_x, pos_y, time_ms, output ready);
endinterface

interface tgr_gesture_if;
    logic                              valid;
    logic                              ready;
    logic [tgr_pkg::GESTURE_BITS-1:0]  gesture;

    modport source (output valid, gesture, input ready);
    modport sink   (input valid, gesture, output ready);
endinterface
`default_nettype wire

// ===== hdl/touch_gesture_recognizer.sv =====
// Touch gesture recognizer: event in, one gesture code out per event.
//
//  channel      dir  handshake        payload
//  i_event      in   valid / ready    op, pos_x, pos_y, time_ms
//  o_gesture    out  valid / ready    gesture
//  i_cfg_*      in   write enable     index, data (no read-back)
//
// One event per cycle when ready is high; its gesture appears in the next cycle,
// out of a single output register. One squared-distance unit (two squarings and an
// add) sets the cycle; squared radii are formed when a radius register is written.
// Synchronous active-low reset clears all state and loads the default thresholds.
// i_event.ready stays high while the output register is empty or being taken.
`default_nettype none
module touch_gesture_recognizer #(
    parameter int COORD_BITS = tgr_pkg::COORD_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    tgr_event_if.sink                               i_event,
    tgr_gesture_if.source                           o_gesture,
    input  wire logic                               i_cfg_we,
    input  wire logic [tgr_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [tgr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int DIST_BITS = 2 * COORD_BITS + 1;
    localparam int CMP_BITS  = (DIST_BITS > tgr_pkg::RSQ_BITS) ? DIST_BITS
                                                                : tgr_pkg::RSQ_BITS;

    logic [tgr_pkg::MS_BITS-1:0]   r_long_press_ms;
    logic [tgr_pkg::MS_BITS-1:0]   r_tap_window_ms;
    logic [tgr_pkg::RSQ_BITS-1:0]  r_drag_sq;
    logic [tgr_pkg::RSQ_BITS-1:0]  r_dtap_sq;
    logic [tgr_pkg::RSQ_BITS-1:0]  r_swipe_sq;

    logic                          r_touching, n_touching;
    logic                          r_drag_active, n_drag_active;
    logic                          r_long_press_seen, n_long_press_seen;
    logic                          r_double_tap_seen, n_double_tap_seen;
    logic                          r_tap_pending, n_tap_pending;
    logic [tgr_pkg::TIME_BITS-1:0] r_start_time, n_start_time;
    logic [tgr_pkg::TIME_BITS-1:0] r_tap_time, n_tap_time;
    logic [COORD_BITS-1:0]         r_start_x, n_start_x;
    logic [COORD_BITS-1:0]         r_start_y, n_start_y;
    logic [COORD_BITS-1:0]         r_tap_x, n_tap_x;
    logic [COORD_BITS-1:0]         r_tap_y, n_tap_y;

    logic                          r_out_valid;
    tgr_pkg::t_gesture             r_gesture, n_gesture;

    logic                          in_xfer;
    tgr_pkg::t_op                  op;
    logic [COORD_BITS-1:0]         ref_x, ref_y, dx, dy;
    logic [DIST_BITS-1:0]          d2;
    logic [CMP_BITS-1:0]           d2_c, drag_c, dtap_c, swipe_c;
    logic [tgr_pkg::TIME_BITS-1:0] since_start, since_tap, win32, long32;
    logic [tgr_pkg::RADIUS_BITS-1:0] cfg_radius;
    logic [tgr_pkg::RSQ_BITS-1:0]  cfg_radius_sq;

    assign in_xfer         = i_event.valid && i_event.ready;
    assign i_event.ready   = !r_out_valid || o_gesture.ready;
    assign o_gesture.valid = r_out_valid;
    assign o_gesture.gesture = r_gesture;
    assign op              = tgr_pkg::t_op'(i_event.op);

    // Distance to the last tap for a down, to the touch start otherwise
    assign ref_x = (op == tgr_pkg::OP_DOWN) ? r_tap_x : r_start_x;
    assign ref_y = (op == tgr_pkg::OP_DOWN) ? r_tap_y : r_start_y;
    assign dx = (i_event.pos_x >= ref_x) ? i_event.pos_x - ref_x : ref_x - i_event.pos_x;
    assign dy = (i_event.pos_y >= ref_y) ? i_event.pos_y - ref_y : ref_y - i_event.pos_y;
    assign d2 = {{(COORD_BITS+1){1'b0}}, dx} * {{(COORD_BITS+1){1'b0}}, dx}
              + {{(COORD_BITS+1){1'b0}}, dy} * {{(COORD_BITS+1){1'b0}}, dy};

    assign d2_c    = CMP_BITS'(d2);
    assign drag_c  = CMP_BITS'(r_drag_sq);
    assign dtap_c  = CMP_BITS'(r_dtap_sq);
    assign swipe_c = CMP_BITS'(r_swipe_sq);

    assign since_start = i_event.time_ms - r_start_time;
    assign since_tap   = i_event.time_ms - r_tap_time;
    assign win32       = tgr_pkg::TIME_BITS'(r_tap_window_ms);
    assign long32      = tgr_pkg::TIME_BITS'(r_long_press_ms);

    assign cfg_radius    = i_cfg_data[tgr_pkg::RADIUS_BITS-1:0];
    assign cfg_radius_sq = {{tgr_pkg::RADIUS_BITS{1'b0}}, cfg_radius}
                         * {{tgr_pkg::RADIUS_BITS{1'b0}}, cfg_radius};

    always_comb begin
        n_touching        = r_touching;
        n_drag_active     = r_drag_active;
        n_long_press_seen = r_long_press_seen;
        n_double_tap_seen = r_double_tap_seen;
        n_tap_pending     = r_tap_pending;
        n_start_time      = r_start_time;
        n_tap_time        = r_tap_time;
        n_start_x         = r_start_x;
        n_start_y         = r_start_y;
        n_tap_x           = r_tap_x;
        n_tap_y           = r_tap_y;
        n_gesture         = tgr_pkg::G_NONE;
        unique case (op)
            tgr_pkg::OP_DOWN: begin
                n_start_x         = i_event.pos_x;
                n_start_y         = i_event.pos_y;
                n_start_time      = i_event.time_ms;
                n_touching        = 1'b1;
                n_drag_active     = 1'b0;
                n_long_press_seen = 1'b0;
                n_double_tap_seen = 1'b0;
                if (r_tap_pending) begin
                    if (since_tap < win32 && d2_c < dtap_c) begin
                        n_double_tap_seen = 1'b1;
                        n_gesture         = tgr_pkg::G_DOUBLE;
                    end else begin
                        n_tap_pending = 1'b0;
                    end
                end
            end
            tgr_pkg::OP_MOVE: begin
                if (d2_c > drag_c) begin
                    n_drag_active = 1'b1;
                end
            end
            tgr_pkg::OP_UP: begin
                n_touching    = 1'b0;
                n_drag_active = 1'b0;
                priority if (r_double_tap_seen || r_long_press_seen) begin
                    n_gesture = tgr_pkg::G_NONE;
                end else if (r_drag_active && d2_c > swipe_c) begin
                    n_gesture = tgr_pkg::G_SWIPE;
                end else if (since_start < win32 && d2_c < drag_c) begin
                    n_tap_pending = 1'b1;
                    n_tap_time    = i_event.time_ms;
                    n_tap_x       = i_event.pos_x;
                    n_tap_y       = i_event.pos_y;
                end else begin
                    n_gesture = tgr_pkg::G_NONE;
                end
            end
            tgr_pkg::OP_TICK: begin
                priority if (r_touching && !r_drag_active && !r_long_press_seen &&
                             !r_double_tap_seen && since_start > long32) begin
                    n_long_press_seen = 1'b1;
                    n_gesture         = tgr_pkg::G_LONG;
                end else if (r_tap_pending && !r_double_tap_seen && since_tap > win32) begin
                    n_tap_pending = 1'b0;
                    n_gesture     = tgr_pkg::G_SINGLE;
                end else begin
                    n_gesture = tgr_pkg::G_NONE;
                end
            end
            default: begin
                n_gesture = tgr_pkg::G_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms <= tgr_pkg::LONG_PRESS_RST;
            r_tap_window_ms <= tgr_pkg::TAP_WINDOW_RST;
            r_drag_sq       <= tgr_pkg::DRAG_SQ_RST;
            r_dtap_sq       <= tgr_pkg::DTAP_SQ_RST;
            r_swipe_sq      <= tgr_pkg::SWIPE_SQ_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tgr_pkg::CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data;
                tgr_pkg::CFG_TAP_WINDOW_MS: r_tap_window_ms <= i_cfg_data;
                tgr_pkg::CFG_DRAG_RADIUS:   r_drag_sq       <= cfg_radius_sq;
                tgr_pkg::CFG_DTAP_RADIUS:   r_dtap_sq       <= cfg_radius_sq;
                tgr_pkg::CFG_SWIPE_RADIUS:  r_swipe_sq      <= cfg_radius_sq;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touching        <= 1'b0;
            r_drag_active     <= 1'b0;
            r_long_press_seen <= 1'b0;
            r_double_tap_seen <= 1'b0;
            r_tap_pending     <= 1'b0;
            r_start_time      <= '0;
            r_tap_time        <= '0;
            r_start_x         <= '0;
            r_start_y         <= '0;
            r_tap_x           <= '0;
            r_tap_y           <= '0;
            r_out_valid       <= 1'b0;
            r_gesture         <= tgr_pkg::G_NONE;
        end else begin
            if (in_xfer) begin
                r_touching        <= n_touching;
                r_drag_active     <= n_drag_active;
                r_long_press_seen <= n_long_press_seen;
                r_double_tap_seen <= n_double_tap_seen;
                r_tap_pending     <= n_tap_pending;
                r_start_time      <= n_start_time;
                r_tap_time        <= n_tap_time;
                r_start_x         <= n_start_x;
                r_start_y         <= n_start_y;
                r_tap_x           <= n_tap_x;
                r_tap_y           <= n_tap_y;
                r_gesture         <= n_gesture;
                r_out_valid       <= 1'b1;
            end else if (o_gesture.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_dtap_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_double_tap_seen |-> r_tap_pending)
        else $error("double tap flagged without a pending tap");

    a_long_excludes_dtap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_long_press_seen && r_double_tap_seen))
        else $error("long press and double tap flagged together");

    a_dtap_only_on_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && op != tgr_pkg::OP_DOWN) |=> r_gesture != tgr_pkg::G_DOUBLE)
        else $error("double tap reported for an event other than down");

    a_swipe_only_on_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && op != tgr_pkg::OP_UP) |=> r_gesture != tgr_pkg::G_SWIPE)
        else $error("swipe reported for an event other than up");
`endif

endmodule
`default_nettype wire
